FILE: rtl/drba_pkg.sv
// Package for the DRAM row buffer access block: sizes, register indexes,
// payload structs and the controller/datapath command and status structs.
// No dependencies.
package drba_pkg;

  // Array geometry (both counts are powers of two)
  localparam int unsigned ROW_COUNT     = 512;
  localparam int unsigned WORDS_PER_ROW = 256;
  localparam int unsigned ROW_W         = $clog2(ROW_COUNT);
  localparam int unsigned COL_W         = $clog2(WORDS_PER_ROW);
  localparam int unsigned DRAM_DEPTH    = ROW_COUNT * WORDS_PER_ROW;
  localparam int unsigned DRAM_AW       = ROW_W + COL_W;
  localparam logic [31:0] REGION_BYTES  = 32'(DRAM_DEPTH * 4);

  // Result and configuration widths
  localparam int unsigned LAT_W     = 10;
  localparam int unsigned DELAY_W   = 8;
  localparam int unsigned CFG_IDX_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_DELAY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COL_DELAY = CFG_IDX_W'(1);

  // Reset values of the delay registers
  localparam logic [DELAY_W-1:0] ROW_DELAY_RST = DELAY_W'(10);
  localparam logic [DELAY_W-1:0] COL_DELAY_RST = DELAY_W'(2);

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] effective_address;
    logic signed [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic [LAT_W-1:0]   latency;
    logic               row_hit;
    logic               address_error;
    logic [31:0]        update_count;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // latch the request
    logic clear;    // write one zero word of the clearing sweep
    logic decode;   // check address, latch hit and latency
    logic swap;     // one step of row write back and load
    logic column;   // column access in the open row
    logic finish;   // load the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic req_error;
    logic req_hit;
    logic swap_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/drba_ctrl.sv
// Controller state machine of the DRAM row buffer access block.
// Depends on drba_pkg for the command and status structs.
module drba_ctrl import drba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DECODE = 6'b000100,
    S_SWAP   = 6'b001000,
    S_COLUMN = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        if (status_i.req_error)    state_d = S_FINISH;
        else if (status_i.req_hit) state_d = S_COLUMN;
        else                       state_d = S_SWAP;
      end
      S_SWAP: begin
        cmd_o.swap = 1'b1;
        if (status_i.swap_last) state_d = S_COLUMN;
      end
      S_COLUMN: begin
        cmd_o.column = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/drba_datapath.sv
// Datapath of the DRAM row buffer access block: DRAM array, row buffer,
// open row tracking, delay registers, update count and output register.
// Depends on drba_pkg; sequenced by drba_ctrl.
module drba_datapath import drba_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_status_t           status_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DELAY_W-1:0]   cfg_wdata_i,
  input  req_t                 in_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output rsp_t                 out_data_o
);

  // Request and decode registers
  req_t              req_q;
  logic              err_q;
  logic              hit_q;
  logic [LAT_W-1:0]  lat_q;

  // Open row state
  logic [ROW_W-1:0]  open_row_q;
  logic              row_valid_q;
  logic [31:0]       upd_q;

  // Delay registers
  logic [DELAY_W-1:0] row_cyc_q;
  logic [DELAY_W-1:0] col_cyc_q;

  // Sweep counters
  logic [DRAM_AW-1:0] clr_q;
  logic [COL_W:0]     k_q;
  logic [COL_W-1:0]   wb_idx_q;

  // Output register
  logic out_valid_q;
  rsp_t out_q;

  // Memories
  logic [31:0] dram_mem [DRAM_DEPTH];
  logic [31:0] rb_mem   [WORDS_PER_ROW];
  logic [31:0] dram_rdata_q;
  logic [31:0] rb_rdata_q;

  // Address decode of the held request
  logic [31:0]      addr_u;
  logic [ROW_W-1:0] req_row;
  logic [COL_W-1:0] req_col;
  logic             req_error;
  logic             req_hit;
  logic [LAT_W-1:0] row_cost;
  logic [LAT_W-1:0] lat_d;
  logic             swap_last;
  logic             swap_wr;

  assign addr_u    = $unsigned(req_q.effective_address);
  assign req_col   = addr_u[2 +: COL_W];
  assign req_row   = addr_u[2 + COL_W +: ROW_W];
  assign req_error = (addr_u[1:0] != 2'b00) || (addr_u >= REGION_BYTES);
  assign req_hit   = row_valid_q && (open_row_q == req_row);

  // Latency: issue cycle, optional write back and load, column access
  always_comb begin
    row_cost = LAT_W'(row_cyc_q);
    if (req_hit) begin
      lat_d = LAT_W'(1) + LAT_W'(col_cyc_q);
    end else if (row_valid_q) begin
      lat_d = LAT_W'(1) + row_cost + row_cost + LAT_W'(col_cyc_q);
    end else begin
      lat_d = LAT_W'(1) + row_cost + LAT_W'(col_cyc_q);
    end
  end

  assign swap_last = (k_q == (COL_W+1)'(WORDS_PER_ROW));
  assign swap_wr   = cmd_i.swap && (k_q != '0);

  assign status_o.clear_last = (clr_q == DRAM_AW'(DRAM_DEPTH - 1));
  assign status_o.req_error  = req_error;
  assign status_o.req_hit    = req_hit;
  assign status_o.swap_last  = swap_last;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // Latch the request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) req_q <= in_data_i;
    if (cmd_i.decode) begin
      err_q <= req_error;
      hit_q <= req_hit;
      lat_q <= lat_d;
    end
    if (cmd_i.swap) wb_idx_q <= k_q[COL_W-1:0];
  end

  // Control state: counters, open row, delays, update count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      k_q         <= '0;
      open_row_q  <= '0;
      row_valid_q <= 1'b0;
      upd_q       <= '0;
      row_cyc_q   <= ROW_DELAY_RST;
      col_cyc_q   <= COL_DELAY_RST;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + DRAM_AW'(1);
      if (cmd_i.decode) begin
        k_q <= '0;
      end else if (cmd_i.swap) begin
        k_q <= k_q + (COL_W+1)'(1);
      end
      if (cmd_i.swap && swap_last) begin
        open_row_q  <= req_row;
        row_valid_q <= 1'b1;
        upd_q       <= upd_q + 32'd1;
      end
      if (cmd_i.column && (req_q.command == CMD_STORE)) upd_q <= upd_q + 32'd1;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ROW_DELAY: row_cyc_q <= cfg_wdata_i;
          REG_COL_DELAY: col_cyc_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // DRAM array: clearing sweep, row write back, row read
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      dram_mem[clr_q] <= '0;
    end else if (swap_wr && row_valid_q) begin
      dram_mem[{open_row_q, wb_idx_q}] <= rb_rdata_q;
    end
    if (cmd_i.swap) dram_rdata_q <= dram_mem[{req_row, k_q[COL_W-1:0]}];
  end

  // Row buffer: load from DRAM, store word, read for write back or load word
  always_ff @(posedge clk_i) begin
    if (swap_wr) begin
      rb_mem[wb_idx_q] <= dram_rdata_q;
    end else if (cmd_i.column && (req_q.command == CMD_STORE)) begin
      rb_mem[req_col] <= $unsigned(req_q.write_data);
    end
    if (cmd_i.swap) begin
      rb_rdata_q <= rb_mem[k_q[COL_W-1:0]];
    end else if (cmd_i.column && (req_q.command == CMD_LOAD)) begin
      rb_rdata_q <= rb_mem[req_col];
    end
  end

  // Output register: load on finish, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.update_count  <= upd_q;
      out_q.address_error <= err_q;
      if (err_q) begin
        out_q.read_data <= '0;
        out_q.latency   <= '0;
        out_q.row_hit   <= 1'b0;
      end else begin
        out_q.read_data <= (req_q.command == CMD_STORE) ? '0 : $signed(rb_rdata_q);
        out_q.latency   <= lat_q;
        out_q.row_hit   <= hit_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/dram_row_buffer_access.sv
// Top level of the DRAM row buffer access block: controller and datapath.
// Depends on drba_pkg, drba_ctrl and drba_datapath.
//
// Word load/store against a 512-row by 256-word DRAM with one open row buffer.
// After reset the block sweeps zeros through the DRAM array, one word a
// cycle, with in_ready_o low; configuration writes are taken throughout.
// After a transfer the request is decoded; a row hit goes to the column
// access, an address error straight to the output register and a row miss
// first writes any open row back and loads the new one word by word through
// the single write port of each array. The result is loaded into the output
// register once it can take it, and in_ready_o rises as the result is loaded.
// A result waits in the output register while the next request is transferred.
// The reported latency field is the modelled DRAM timing from the delay
// registers, not the time the block itself takes.
module dram_row_buffer_access import drba_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DELAY_W-1:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  req_t                 in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rsp_t                 out_data_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  drba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  drba_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // One request at a time: no new transfer right after one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while previous one still in flight");

  // A result only appears at the end of an access
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised without an access in progress");

  // A valid access always costs at least the issue cycle
  a_latency_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.address_error) |->
      (out_data_o.latency != '0))
    else $error("zero latency on a valid access");

  // An erroneous access never reports a hit
  a_error_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.address_error) |-> !out_data_o.row_hit)
    else $error("row hit flagged on an address error");

endmodule
